// ===== sv/prd_pkg.sv =====
package prd_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;           // A - P, B - A
    localparam int MAG_WIDTH   = COORD_WIDTH;               // magnitude of a difference
    localparam int PROD_WIDTH  = 2 * MAG_WIDTH;             // one product
    localparam int SUM_WIDTH   = PROD_WIDTH + 2;            // sum of three products
    localparam int CSQ_WIDTH   = 2 * SUM_WIDTH;             // c squared
    localparam int DIST_WIDTH  = 2 * COORD_WIDTH + 2;
    localparam int HALF_WIDTH  = SUM_WIDTH / 2 + 1;         // split for c squared

    // sums handed from the dot-product stage to the divide stage
    typedef struct packed {
        logic [SUM_WIDTH-1:0] pa_sq;
        logic [SUM_WIDTH-1:0] n_sq;
        logic [SUM_WIDTH-1:0] c_mag;
        logic                 behind;
    } t_dot;

endpackage

// ===== sv/prd_dot.sv =====
// Differences, magnitudes, products and sums: four register stages.
module prd_dot (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_p [3],
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_a [3],
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_b [3],
    output logic                                o_valid,
    output prd_pkg::t_dot                       o_dot
);
    localparam int DW = prd_pkg::DIFF_WIDTH;
    localparam int MW = prd_pkg::MAG_WIDTH;
    localparam int PW = prd_pkg::PROD_WIDTH;
    localparam int SW = prd_pkg::SUM_WIDTH;

    logic [3:0] r_v;
    logic [MW:0]   r_mp [3];   // one spare bit beyond MAG_WIDTH
    logic [MW:0]   r_mn [3];
    logic [2:0]    r_neg;
    logic [PW+1:0] r_pp [3];
    logic [PW+1:0] r_nn [3];
    logic [PW+1:0] r_pn [3];
    logic [2:0]    r_neg2;
    logic [SW+1:0] r_pa_sq, r_n_sq, r_cp, r_cn;
    prd_pkg::t_dot r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: differences as sign and magnitude
            for (int k = 0; k < 3; k++) begin
                logic signed [DW-1:0] pa, n;
                pa = DW'(i_a[k]) - DW'(i_p[k]);
                n  = DW'(i_b[k]) - DW'(i_a[k]);
                r_mp[k]  <= pa[DW-1] ? (MW+1)'(-pa) : (MW+1)'(pa);
                r_mn[k]  <= n[DW-1]  ? (MW+1)'(-n)  : (MW+1)'(n);
                r_neg[k] <= pa[DW-1] ^ n[DW-1];
            end
            // stage 2: products
            for (int k = 0; k < 3; k++) begin
                r_pp[k] <= (PW+2)'(r_mp[k]) * (PW+2)'(r_mp[k]);
                r_nn[k] <= (PW+2)'(r_mn[k]) * (PW+2)'(r_mn[k]);
                r_pn[k] <= (PW+2)'(r_mp[k]) * (PW+2)'(r_mn[k]);
            end
            r_neg2 <= r_neg;
            // stage 3: sums, dot product split by sign
            r_pa_sq <= (SW+2)'(r_pp[0]) + (SW+2)'(r_pp[1]) + (SW+2)'(r_pp[2]);
            r_n_sq  <= (SW+2)'(r_nn[0]) + (SW+2)'(r_nn[1]) + (SW+2)'(r_nn[2]);
            r_cp <= (r_neg2[0] ? '0 : (SW+2)'(r_pn[0])) + (r_neg2[1] ? '0 : (SW+2)'(r_pn[1]))
                  + (r_neg2[2] ? '0 : (SW+2)'(r_pn[2]));
            r_cn <= (r_neg2[0] ? (SW+2)'(r_pn[0]) : '0) + (r_neg2[1] ? (SW+2)'(r_pn[1]) : '0)
                  + (r_neg2[2] ? (SW+2)'(r_pn[2]) : '0);
            // stage 4: compare and magnitude of c
            r_out.pa_sq  <= SW'(r_pa_sq);
            r_out.n_sq   <= SW'(r_n_sq);
            r_out.behind <= (r_cp > r_cn) || (r_n_sq == '0);
            r_out.c_mag  <= SW'(r_cn - r_cp);
        end
    end

    assign o_valid = r_v[3];
    assign o_dot   = r_out;
endmodule

// ===== sv/prd_div.sv =====
// c squared by partial products, then a restoring divider at one quotient bit per stage.
module prd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  prd_pkg::t_dot                 i_dot,
    output logic                          o_valid,
    output logic [prd_pkg::DIST_WIDTH-1:0] o_dist_sq,
    output logic                          o_behind
);
    localparam int SW = prd_pkg::SUM_WIDTH;
    localparam int QW = prd_pkg::CSQ_WIDTH;
    localparam int HW = prd_pkg::HALF_WIDTH;
    localparam int NS = QW + 4;     // partial products, recombine, load, divide, finish

    // c = h*2^HW + l; c^2 = hh*2^2HW + 2hl*2^HW + ll
    logic [SW-1:0]   r_hl_pa, r_hl_n, r_sq_pa, r_sq_n;
    logic            r_hl_b,  r_sq_b;
    logic [2*HW-1:0] r_hh, r_hl, r_ll;
    logic [QW-1:0]   r_csq;

    logic [QW-1:0]   r_rem [QW+1];
    logic [QW-1:0]   r_num [QW+1];
    logic [QW-1:0]   r_q   [QW+1];
    logic [SW-1:0]   r_d   [QW+1];
    logic [SW-1:0]   r_pa  [QW+1];
    logic            r_b   [QW+1];
    logic [prd_pkg::DIST_WIDTH-1:0] r_dist;
    logic            r_behind;
    logic [NS-1:0]   r_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NS-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // partial products of c squared
            r_hh <= (2*HW)'(i_dot.c_mag[SW-1:HW]) * (2*HW)'(i_dot.c_mag[SW-1:HW]);
            r_hl <= (2*HW)'(i_dot.c_mag[SW-1:HW]) * (2*HW)'(i_dot.c_mag[HW-1:0]);
            r_ll <= (2*HW)'(i_dot.c_mag[HW-1:0]) * (2*HW)'(i_dot.c_mag[HW-1:0]);
            r_hl_pa <= i_dot.pa_sq;
            r_hl_n  <= i_dot.n_sq;
            r_hl_b  <= i_dot.behind;
            // recombine
            r_csq <= (QW'(r_hh) << (2*HW)) + (QW'(r_hl) << (HW+1)) + QW'(r_ll);
            r_sq_pa <= r_hl_pa;
            r_sq_n  <= r_hl_n;
            r_sq_b  <= r_hl_b;
            // load divider
            r_rem[0] <= '0;
            r_num[0] <= r_csq;
            r_q[0]   <= '0;
            r_d[0]   <= r_sq_n;
            r_pa[0]  <= r_sq_pa;
            r_b[0]   <= r_sq_b;
            // one quotient bit per stage
            for (int i = 0; i < QW; i++) begin
                logic [QW:0] t;
                t = {r_rem[i], r_num[i][QW-1]};
                if (!r_b[i] && t >= (QW+1)'(r_d[i])) begin
                    r_rem[i+1] <= QW'(t - (QW+1)'(r_d[i]));
                    r_q[i+1]   <= {r_q[i][QW-2:0], 1'b1};
                end else begin
                    r_rem[i+1] <= QW'(t);
                    r_q[i+1]   <= {r_q[i][QW-2:0], 1'b0};
                end
                r_num[i+1] <= {r_num[i][QW-2:0], 1'b0};
                r_d[i+1]   <= r_d[i];
                r_pa[i+1]  <= r_pa[i];
                r_b[i+1]   <= r_b[i];
            end
            // subtract and clamp
            if (r_b[QW]) begin
                r_dist <= prd_pkg::DIST_WIDTH'(r_pa[QW]);
            end else if (r_q[QW] >= QW'(r_pa[QW])) begin
                r_dist <= '0;
            end else begin
                r_dist <= prd_pkg::DIST_WIDTH'(QW'(r_pa[QW]) - r_q[QW]);
            end
            r_behind <= r_b[QW];
        end
    end

    assign o_valid   = r_v[NS-1];
    assign o_dist_sq = r_dist;
    assign o_behind  = r_behind;
endmodule

// ===== sv/point_to_ray_distance_squared.sv =====
// Squared distance from a query point to a ray, fixed point.
// Input channel: i_valid/o_ready with nine signed Q15.8 coordinates (point,
// ray origin, second point on the ray). Output channel: o_valid/i_ready with
// o_dist_sq (unsigned, 16 fraction bits) and o_behind_origin.
// One result word per input word, in order.
// The pipeline has 108 register stages (4 dot-product stages, 2 for c squared,
// 1 divider load, 100 divider stages at one quotient bit each, 1 clamp).
// Throughput: one word per cycle while the receiver does not stall the output.
// The whole pipeline advances together whenever the output register is empty
// or its word is being taken. When the receiver holds i_ready low with a
// result waiting, the pipeline freezes and o_ready drops in the same cycle,
// so nothing is lost or repeated.
// Reset (synchronous, active low) clears all valid bits; payload is not reset.
module point_to_ray_distance_squared (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_point_x,
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_point_y,
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_point_z,
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_origin_x,
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_origin_y,
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_origin_z,
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_toward_x,
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_toward_y,
    input  logic signed [prd_pkg::COORD_WIDTH-1:0] i_toward_z,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [prd_pkg::DIST_WIDTH-1:0]        o_dist_sq,
    output logic                                  o_behind_origin
);
    logic signed [prd_pkg::COORD_WIDTH-1:0] w_p [3], w_a [3], w_b [3];
    logic          w_en, w_dot_v;
    prd_pkg::t_dot w_dot;

    assign w_p = '{i_point_x, i_point_y, i_point_z};
    assign w_a = '{i_origin_x, i_origin_y, i_origin_z};
    assign w_b = '{i_toward_x, i_toward_y, i_toward_z};

    // advance when the last stage is empty or its word is taken
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    prd_dot u_dot (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_p     (w_p),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_valid (w_dot_v),
        .o_dot   (w_dot)
    );

    prd_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_dot_v),
        .i_dot     (w_dot),
        .o_valid   (o_valid),
        .o_dist_sq (o_dist_sq),
        .o_behind  (o_behind_origin)
    );
endmodule

// ===== test/tb.sv =====
module tb;
    typedef logic signed [prd_pkg::COORD_WIDTH-1:0] t_coord;
    // one input word: point xyz, origin xyz, toward xyz
    typedef t_coord t_word[9];

    localparam int STALL_LIMIT = 4000;
    localparam int N_RANDOM    = 730;

    // expected results and the squared-distance predictor
    class t_dist_scoreboard;
        typedef struct {
            logic [prd_pkg::DIST_WIDTH-1:0] dist_sq;
            logic                           behind;
        } t_result;

        t_result expected_q[$];
        int      errors  = 0;
        int      checked = 0;
        int      n_behind = 0;
        int      n_clamped = 0;

        function void note(t_word w);
            logic signed [63:0] p, a, b, pa, n, pa_sq, n_sq, c;
            logic [127:0] csq, q;
            t_result r;
            pa_sq = 0;
            n_sq  = 0;
            c     = 0;
            for (int k = 0; k < 3; k++) begin
                p = w[k];
                a = w[3 + k];
                b = w[6 + k];
                pa = a - p;
                n  = b - a;
                pa_sq += pa * pa;
                n_sq  += n * n;
                c     += pa * n;
            end
            if (c > 0 || n_sq == 0) begin
                r.behind  = 1'b1;
                r.dist_sq = pa_sq[prd_pkg::DIST_WIDTH-1:0];
                n_behind++;
            end else begin
                // exact floor of c^2 / |n|^2, then clamp at zero
                csq = {64'd0, -c} * {64'd0, -c};
                q   = csq / {64'd0, n_sq};
                r.behind = 1'b0;
                if (q >= {64'd0, pa_sq}) begin
                    r.dist_sq = '0;
                    n_clamped++;
                end else begin
                    r.dist_sq = prd_pkg::DIST_WIDTH'(pa_sq - q[63:0]);
                end
            end
            expected_q.push_back(r);
        endfunction

        function void check(logic [prd_pkg::DIST_WIDTH-1:0] dist_sq, logic behind);
            t_result r;
            checked++;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected: dist_sq %0d", dist_sq);
                errors++;
                return;
            end
            r = expected_q.pop_front();
            if (dist_sq !== r.dist_sq) begin
                $error("dist_sq: expected %0d, got %0d", r.dist_sq, dist_sq);
                errors++;
            end
            if (behind !== r.behind) begin
                $error("behind_origin: expected %0d, got %0d", r.behind, behind);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    t_coord                i_point_x = '0, i_point_y = '0, i_point_z = '0;
    t_coord                i_origin_x = '0, i_origin_y = '0, i_origin_z = '0;
    t_coord                i_toward_x = '0, i_toward_y = '0, i_toward_z = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic [prd_pkg::DIST_WIDTH-1:0] o_dist_sq;
    logic                  o_behind_origin;

    t_dist_scoreboard sb = new();
    bit  hold_req = 0;
    int  idle_cycles = 0;
    int  n_sent = 0;

    point_to_ray_distance_squared dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result checks and the no-progress watchdog
    always @(posedge i_clk) begin
        if (o_valid && i_ready)
            sb.check(o_dist_sq, o_behind_origin);
        if ((o_valid && i_ready) || (i_valid && o_ready))
            idle_cycles <= 0;
        else if (i_rst_n)
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, quiet stretches, and one long hold-off on request
    initial begin
        int mode;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
                hold_req = 0;
            end else begin
                mode = $urandom_range(0, 3);
                if (mode == 0) begin
                    i_ready <= 1'b1;
                    repeat ($urandom_range(20, 80)) @(posedge i_clk);
                end else begin
                    i_ready <= 1'b0;
                    repeat (pick_gap()) @(posedge i_clk);
                    i_ready <= 1'b1;
                    @(posedge i_clk);
                end
            end
        end
    end

    // offer one word after an optional gap, return once it is taken
    task automatic send_word(t_word w, int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_point_x  <= w[0];
        i_point_y  <= w[1];
        i_point_z  <= w[2];
        i_origin_x <= w[3];
        i_origin_y <= w[4];
        i_origin_z <= w[5];
        i_toward_x <= w[6];
        i_toward_y <= w[7];
        i_toward_z <= w[8];
        do @(posedge i_clk); while (!o_ready);
        sb.note(w);
        n_sent++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_word make_word(int kind);
        t_word  w;
        int     t;
        t_coord d;
        case (kind)
            0: foreach (w[k]) w[k] = t_coord'($urandom);
            1: foreach (w[k]) w[k] = t_coord'($urandom_range(0, 4095)) - 2048;
            2: begin
                // point near the ray, ahead of the origin
                t = $urandom_range(0, 6);
                for (int k = 0; k < 3; k++) begin
                    w[3 + k] = t_coord'($urandom_range(0, 65535)) - 32768;
                    d = t_coord'($urandom_range(0, 1023)) - 512;
                    w[6 + k] = w[3 + k] + d;
                    w[k] = w[3 + k] + t * d + (t_coord'($urandom_range(0, 31)) - 16);
                end
            end
            default: begin
                // degenerate ray
                foreach (w[k]) w[k] = t_coord'($urandom);
                for (int k = 0; k < 3; k++) w[6 + k] = w[3 + k];
            end
        endcase
        return w;
    endfunction

    localparam t_coord CMAX = {1'b0, {(prd_pkg::COORD_WIDTH-1){1'b1}}};
    localparam t_coord CMIN = {1'b1, {(prd_pkg::COORD_WIDTH-1){1'b0}}};

    initial begin
        t_word w;
        int    r;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed words: extremes, degenerate, perpendicular, behind, on the ray
        w = '{default: 0};                                     send_word(w, 0);
        w = '{default: CMAX};                                  send_word(w, 1);
        w = '{default: CMIN};                                  send_word(w, 0);
        w = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMIN}; send_word(w, 0);
        w = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX}; send_word(w, 2);
        w = '{CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMAX, CMIN, CMAX}; send_word(w, 0);
        w = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX}; send_word(w, 0);
        w = '{CMAX, CMIN, CMAX, 0, 0, 0, CMIN, CMAX, CMIN};    send_word(w, 0);
        w = '{0, 256, 0, 0, 0, 0, 256, 0, 0};                  send_word(w, 0);
        w = '{-256, 0, 0, 0, 0, 0, 256, 0, 0};                 send_word(w, 3);
        w = '{512, 0, 0, 0, 0, 0, 256, 0, 0};                  send_word(w, 0);
        w = '{512, 1, 0, 0, 0, 0, 256, 0, 0};                  send_word(w, 0);
        w = '{300, 700, -5, 17, 17, 17, 17, 17, 17};           send_word(w, 0);
        w = '{1, -1, 1, 0, 0, 0, 3, 5, -7};                    send_word(w, 0);
        w = '{-1, -1, -1, 0, 0, 0, 0, 0, 1};                   send_word(w, 0);
        w = '{CMAX, CMAX, 0, CMAX, 0, 0, CMIN, 0, 0};          send_word(w, 0);
        w = '{0, 0, 0, 1, 1, 1, CMAX, CMAX, CMAX};             send_word(w, 0);
        w = '{CMIN, 0, 0, 0, 0, 0, 1, 0, 0};                   send_word(w, 0);
        drain();

        // random words, with a long receiver hold-off and a full drain midway
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == 200) hold_req = 1;
            if (i == 450) drain();
            r = $urandom_range(0, 99);
            w = make_word(r < 35 ? 0 : r < 55 ? 1 : r < 90 ? 2 : 3);
            send_word(w, (i >= 200 && i < 330) ? 0 : pick_gap());
        end
        drain();
        repeat (150) @(posedge i_clk);

        $display("covered %0d words: %0d behind or degenerate, %0d clamped to zero",
                 n_sent, sb.n_behind, sb.n_clamped);
        $display("%0d results checked, %0d errors", sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
